// ===== rtl/bffa_pkg.sv =====
`default_nettype none

package bffa_pkg;

    // Fixed field widths of the request and result items
    localparam int KIND_W    = 2;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int LEN_W     = 5;
    localparam int OFF_W     = 10;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_MARK,
        ST_HINT,
        ST_COMMIT,
        ST_FREE_CLR,
        ST_DONE
    } t_state;

    // Result source select
    typedef enum logic [1:0] {
        RES_FAIL,
        RES_SLOT,
        RES_ALLOC
    } t_res;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic scan_start;
        logic scan_run;
        logic hint_start;
        logic hint_run;
        logic wr_step;
        logic wr_val;
        logic wr_start_free;
        logic take_hint;
        logic commit_alloc;
        logic commit_free;
        logic out_load;
        t_res res_sel;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic  clr_last;
        t_kind kind;
        logic  in_range;
        logic  len_ok;
        logic  len_zero;
        logic  slot_valid;
        logic  size_zero;
        logic  found;
        logic  scan_fail;
        logic  s_is_hint;
        logic  wr_last;
        logic  hint_done;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/bffa_ctrl.sv =====
`default_nettype none

module bffa_ctrl import bffa_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_s_valid,
    input  wire   i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_s_ready
);

    t_state r_state, n_state;
    t_res   r_res, n_res;

    // State and result-select registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_res   <= RES_FAIL;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_res         = r_res;
        o_cmd         = '0;
        o_cmd.res_sel = r_res;
        o_s_ready     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = ST_DONE;
                n_res   = RES_FAIL;
                if (i_stat.in_range) begin
                    case (i_stat.kind)
                        KIND_LOOKUP: begin
                            if (!i_stat.size_zero) begin
                                n_res = RES_SLOT;
                            end
                        end
                        KIND_FREE: begin
                            if (i_stat.slot_valid) begin
                                n_res = RES_SLOT;
                                if (i_stat.size_zero) begin
                                    o_cmd.commit_free = 1'b1;
                                end else begin
                                    o_cmd.wr_start_free = 1'b1;
                                    n_state             = ST_FREE_CLR;
                                end
                            end
                        end
                        KIND_ALLOC: begin
                            if (i_stat.len_ok) begin
                                if (i_stat.len_zero) begin
                                    o_cmd.take_hint = 1'b1;
                                    n_state         = ST_COMMIT;
                                end else begin
                                    o_cmd.scan_start = 1'b1;
                                    n_state          = ST_SCAN;
                                end
                            end
                        end
                        default: begin
                            n_res = RES_FAIL;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.found) begin
                    n_state = ST_MARK;
                end else if (i_stat.scan_fail) begin
                    n_res   = RES_FAIL;
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                o_cmd.wr_step = 1'b1;
                o_cmd.wr_val  = 1'b1;
                if (i_stat.wr_last) begin
                    if (i_stat.s_is_hint) begin
                        o_cmd.hint_start = 1'b1;
                        n_state          = ST_HINT;
                    end else begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_HINT: begin
                o_cmd.hint_run = 1'b1;
                if (i_stat.hint_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit_alloc = 1'b1;
                n_res              = RES_ALLOC;
                n_state            = ST_DONE;
            end
            ST_FREE_CLR: begin
                o_cmd.wr_step = 1'b1;
                if (i_stat.wr_last) begin
                    o_cmd.commit_free = 1'b1;
                    n_state           = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bffa_dp.sv =====
`default_nettype none

module bffa_dp import bffa_pkg::*; #(
    parameter int GRID_DIM  = 8,
    parameter int MAX_UNITS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cmd             i_cmd,
    input  t_kind            i_kind,
    input  wire  [ROW_W-1:0] i_row,
    input  wire  [COL_W-1:0] i_col,
    input  wire  [LEN_W-1:0] i_length,
    output t_stat            o_stat,
    output logic             o_res_ok,
    output logic [OFF_W-1:0] o_res_off,
    output logic [LEN_W-1:0] o_res_size
);

    localparam int NUM_SLOTS = GRID_DIM * GRID_DIM;
    localparam int NUM_UNITS = NUM_SLOTS * MAX_UNITS;
    localparam int UW        = $clog2(NUM_UNITS);
    localparam int SLW       = $clog2(NUM_SLOTS);
    localparam int CW        = UW + 1;
    localparam int SLOT_W    = 1 + UW + LEN_W;

    // Usage map (one bit per unit) and slot table {valid, offset, size}
    logic              r_umap [NUM_UNITS];
    logic [SLOT_W-1:0] r_slot_mem [NUM_SLOTS];

    // Captured request
    t_kind            r_kind;
    logic             r_in_range;
    logic [SLW-1:0]   r_slot;
    logic [LEN_W-1:0] r_len;
    logic [SLOT_W-1:0] r_slot_q;

    // Scan engine
    logic [UW-1:0]    r_rd_addr;
    logic [UW-1:0]    r_q_addr;
    logic             r_q_valid;
    logic             r_umap_q;
    logic [LEN_W-1:0] r_run;
    logic [CW-1:0]    r_left;
    logic [UW-1:0]    r_found_s;
    logic [UW-1:0]    r_hint;

    // Write walker
    logic [UW-1:0]    r_wr_ptr;
    logic [LEN_W-1:0] r_wr_left;

    logic             in_range;
    logic [SLW-1:0]   in_slot;
    logic             issue;
    logic             q_free;
    logic [LEN_W-1:0] run_base;
    logic [LEN_W-1:0] run_inc;
    logic             found;
    logic [UW-1:0]    found_s;
    logic             left_last;
    logic             umap_we;
    logic             slot_we;
    logic [SLW-1:0]   slot_wa;
    logic [SLOT_W-1:0] slot_wd;
    logic [UW-1:0]    slot_q_off;
    logic [LEN_W-1:0] slot_q_size;
    int               scan_end;
    int               scan_lim;
    int               hint_from;

    // Decode the slot index of the incoming request
    always_comb begin
        in_range = (int'(i_row) < GRID_DIM) && (int'(i_col) < GRID_DIM);
        in_slot  = in_range ? SLW'(int'(i_row) * GRID_DIM + int'(i_col)) : '0;
    end

    assign slot_q_off  = r_slot_q[UW+LEN_W-1:LEN_W];
    assign slot_q_size = r_slot_q[LEN_W-1:0];

    // Scan processing on the registered map read
    always_comb begin
        issue     = i_cmd.scan_run | i_cmd.hint_run;
        q_free    = !r_umap_q;
        run_base  = (r_q_addr == '0) ? '0 : r_run;
        run_inc   = run_base + LEN_W'(1);
        found     = i_cmd.scan_run && r_q_valid && q_free && (run_inc == r_len);
        found_s   = UW'(int'(r_q_addr) - int'(r_len) + 1);
        left_last = (r_left == CW'(1));
        scan_end  = int'(r_hint) + int'(r_len) - 1;
        scan_lim  = (scan_end > NUM_UNITS) ? NUM_UNITS : scan_end;
        hint_from = int'(r_found_s) + int'(r_len);
    end

    // Capture the request and read its slot entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_in_range <= in_range;
            r_slot     <= in_slot;
            r_len      <= i_length;
            r_slot_q   <= r_slot_mem[in_slot];
        end
    end

    // Usage map read port
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_umap_q <= r_umap[r_rd_addr];
        end
    end

    // Usage map write port
    assign umap_we = i_cmd.clr_step | i_cmd.wr_step;

    always_ff @(posedge i_clk) begin
        if (umap_we) begin
            r_umap[r_wr_ptr] <= i_cmd.clr_step ? 1'b0 : i_cmd.wr_val;
        end
    end

    // Slot table write port
    always_comb begin
        slot_we = 1'b0;
        slot_wa = r_slot;
        slot_wd = '0;
        if (i_cmd.clr_step) begin
            slot_we = (int'(r_wr_ptr) < NUM_SLOTS);
            slot_wa = r_wr_ptr[SLW-1:0];
        end else if (i_cmd.commit_alloc) begin
            slot_we = 1'b1;
            slot_wd = {1'b1, r_found_s, r_len};
        end else if (i_cmd.commit_free) begin
            slot_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
    end

    // Control registers of the walkers: reset clears them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_hint    <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_q_valid <= issue;
            if (i_cmd.clr_step || i_cmd.wr_step) begin
                r_wr_ptr <= r_wr_ptr + UW'(1);
            end else if (found) begin
                r_wr_ptr <= found_s;
            end else if (i_cmd.wr_start_free) begin
                r_wr_ptr <= slot_q_off;
            end
            if (i_cmd.hint_run && r_q_valid && q_free) begin
                r_hint <= r_q_addr;
            end
        end
    end

    // Scan counters and found position
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_q_addr  <= r_rd_addr;
            r_rd_addr <= (int'(r_rd_addr) == NUM_UNITS - 1) ? '0 : r_rd_addr + UW'(1);
        end else if (i_cmd.scan_start) begin
            r_rd_addr <= r_hint;
        end else if (i_cmd.hint_start) begin
            r_rd_addr <= UW'((hint_from >= NUM_UNITS) ? hint_from - NUM_UNITS : hint_from);
        end
        if (i_cmd.scan_start) begin
            r_run  <= '0;
            r_left <= CW'(NUM_UNITS - int'(r_hint) + scan_lim);
        end else if (i_cmd.hint_start) begin
            r_left <= CW'(NUM_UNITS - int'(r_len));
        end else if (issue && r_q_valid) begin
            r_run  <= q_free ? run_inc : '0;
            r_left <= r_left - CW'(1);
        end
        if (found) begin
            r_found_s <= found_s;
        end else if (i_cmd.take_hint) begin
            r_found_s <= r_hint;
        end
        if (found) begin
            r_wr_left <= r_len;
        end else if (i_cmd.wr_start_free) begin
            r_wr_left <= slot_q_size;
        end else if (i_cmd.wr_step) begin
            r_wr_left <= r_wr_left - LEN_W'(1);
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.clr_last   = (int'(r_wr_ptr) == NUM_UNITS - 1);
        o_stat.kind       = r_kind;
        o_stat.in_range   = r_in_range;
        o_stat.len_ok     = (int'(r_len) <= MAX_UNITS);
        o_stat.len_zero   = (r_len == '0);
        o_stat.slot_valid = r_slot_q[SLOT_W-1];
        o_stat.size_zero  = (slot_q_size == '0);
        o_stat.found      = found;
        o_stat.scan_fail  = i_cmd.scan_run && r_q_valid && !found && left_last;
        o_stat.s_is_hint  = (r_found_s == r_hint);
        o_stat.wr_last    = (r_wr_left == LEN_W'(1));
        o_stat.hint_done  = i_cmd.hint_run && r_q_valid && (q_free || left_last);
    end

    // Result select
    always_comb begin
        o_res_ok   = 1'b0;
        o_res_off  = '0;
        o_res_size = '0;
        case (i_cmd.res_sel)
            RES_SLOT: begin
                o_res_ok   = 1'b1;
                o_res_off  = OFF_W'(slot_q_off);
                o_res_size = slot_q_size;
            end
            RES_ALLOC: begin
                o_res_ok   = 1'b1;
                o_res_off  = OFF_W'(r_found_s);
                o_res_size = r_len;
            end
            default: begin
                o_res_ok = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_first_fit_allocator.sv =====
// Bitmap first-fit allocator.
// Requests arrive on the slave stream (i_s_*): tuser carries the kind
// (allocate, free, look-up), tdata the slot row, column and length. Each
// request yields exactly one result transaction on the master stream (o_m_*):
// tuser is the success flag, tdata the region offset and size.
// After reset the block sweeps the usage map and slot table clean, one unit
// per cycle; o_s_tready stays low meanwhile. One request is worked at a time.
// A look-up needs no map access; a free clears the region's units in the map,
// and an allocate scans up to map size + length - 1 map units from the
// next-free hint, marks length units, and, when the run starts at the hint,
// moves the hint by inspecting up to map size - length more units. The usage
// map has one read port, so every scan step inspects one unit per cycle.
// The result sits in an output register: the next request is accepted while
// it waits; a stalled receiver holds it there and the block waits with the
// following result until the register frees up.
`default_nettype none

module bitmap_first_fit_allocator import bffa_pkg::*; #(
    parameter int GRID_DIM  = 8,
    parameter int MAX_UNITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire  [S_TDATA_W-1:0] i_s_tdata,   // row[2:0], col[5:3], length[10:6]
    input  wire  [KIND_W-1:0]    i_s_tuser,   // kind[1:0]
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // offset[9:0], region_size[14:10]
    output logic                 o_m_tuser    // ok[0]
);

    t_cmd             cmd;
    t_stat            stat;
    logic             res_ok;
    logic [OFF_W-1:0] res_off;
    logic [LEN_W-1:0] res_size;
    logic             out_free;

    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic                 r_m_tuser;

    assign out_free = !r_m_tvalid || i_m_tready;

    bffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_s_ready  (o_s_tready)
    );

    bffa_dp #(
        .GRID_DIM  (GRID_DIM),
        .MAX_UNITS (MAX_UNITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (t_kind'(i_s_tuser)),
        .i_row      (i_s_tdata[ROW_W-1:0]),
        .i_col      (i_s_tdata[ROW_W+COL_W-1:ROW_W]),
        .i_length   (i_s_tdata[ROW_W+COL_W+LEN_W-1:ROW_W+COL_W]),
        .o_stat     (stat),
        .o_res_ok   (res_ok),
        .o_res_off  (res_off),
        .o_res_size (res_size)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_m_tdata <= {(M_TDATA_W - OFF_W - LEN_W)'(0), res_size, res_off};
            r_m_tuser <= res_ok;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

`default_nettype wire

// ===== rtl/bffa_checker.sv =====
`default_nettype none

module bffa_checker import bffa_pkg::*; (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_s_tvalid,
    input wire                 o_s_tready,
    input wire [S_TDATA_W-1:0] i_s_tdata,
    input wire [KIND_W-1:0]    i_s_tuser,
    input wire                 o_m_tvalid,
    input wire                 i_m_tready,
    input wire [M_TDATA_W-1:0] o_m_tdata,
    input wire                 o_m_tuser
);

    // Reset starts the clearing sweep: nothing offered, nothing accepted
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("outputs active right after reset");

    // One request at a time: ready drops after each accepted transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in work");

    // A failed result carries zero offset and size
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("failed result with nonzero fields");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
